[design/audio_record_loop_player_defines.svh]
// Assertion helpers used by the audio_record_loop_player RTL.
// Each helper checks on the rising edge of clk and is held off while rst is high.
`ifndef AUDIO_RECORD_LOOP_PLAYER_DEFINES_SVH
`define AUDIO_RECORD_LOOP_PLAYER_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ARLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ARLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/arlp_pkg.sv]
package arlp_pkg;

  // Operating modes.
  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_TONE = 2'd1,
    MODE_REC  = 2'd2,
    MODE_PLAY = 2'd3
  } mode_t;

  // Item kinds carried in s_tuser.
  typedef enum logic [2:0] {
    ACT_FRAME    = 3'd0,
    ACT_PASS     = 3'd1,
    ACT_TONE     = 3'd2,
    ACT_REC      = 3'd3,
    ACT_PLAY     = 3'd4,
    ACT_VOL_UP   = 3'd5,
    ACT_VOL_DOWN = 3'd6,
    ACT_TABLE_WR = 3'd7
  } action_t;

  // Where the sample of a result comes from.
  typedef enum logic [1:0] {
    SRC_INPUT = 2'd0,
    SRC_TONE  = 2'd1,
    SRC_STORE = 2'd2,
    SRC_ZERO  = 2'd3
  } src_t;

  // Register map (byte addresses).
  localparam logic [1:0] ADDR_PHASE_STEP = 2'd0;

  localparam logic [7:0] PHASE_STEP_RESET = 8'd16;
  localparam logic [5:0] VOLUME_RESET     = 6'd40;
  localparam logic [5:0] VOLUME_MAX       = 6'd63;
  localparam logic [5:0] VOLUME_STEP      = 6'd5;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 15;

endpackage

[design/audio_record_loop_player.sv]
// Audio record / loop player.
// Input stream (s_*): one transfer is one stereo frame or one command. s_tuser holds the
// item kind (frame, passthrough, tone, record, playback, volume up/down, table write);
// s_tdata holds the left sample (or table word), the right sample and the table index.
// Output stream (m_*): exactly one result transfer per input transfer, in order. m_tuser
// flags a result that carries a sample; m_tdata holds the samples and the mode, volume,
// recorded length and playback-rejected status after the item.
// phase_step (tone phase increment per frame) is written over the APB port at address 0.
// Throughput: one item per cycle while the output is not stalled and the table clear is
// done. Each item passes the read stage, with the registered read of the record store or
// tone table, then the output register. Record and playback share the store, which is
// written or read at most once per item.
// Reset: mode, volume, phase step, counters and valid flags return to their defaults;
// then the tone table is zeroed one entry per cycle, with s_tready low until it ends.
// Contents of the record store are not cleared; playback only reads what was recorded.
// Stall: when m_tready is low the result holds in the output register; one more item is
// taken into the read stage, after which s_tready drops until the output drains.
`include "audio_record_loop_player_defines.svh"

module audio_record_loop_player #(
  parameter int RECORD_FRAMES = 16384,
  parameter int TONE_ENTRIES  = 256
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // in_left[15:0], in_right[31:16], tone_index[39:32]
  input  logic [2:0]  s_tuser,  // action[2:0]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // out_left[15:0], out_right[31:16], mode_now[33:32],
                                // volume_now[39:34], recorded_frames[54:40], rejected[55]
  output logic        m_tuser,  // sample_valid
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(RECORD_FRAMES);
  localparam int LW = $clog2(RECORD_FRAMES + 1);
  localparam int TW = $clog2(TONE_ENTRIES);
  localparam int SW = arlp_pkg::SAMPLE_W;
  localparam int CW = arlp_pkg::COUNT_W;

  // Tone table index: phase modulo table size by restoring subtraction (quotient < 16).
  function automatic logic [TW-1:0] tone_addr(input logic [7:0] ph);
    logic [13:0] r;
    r = 14'(ph);
    for (int k = 3; k >= 0; k--) begin
      if (r >= 14'(TONE_ENTRIES << k)) begin
        r = r - 14'(TONE_ENTRIES << k);
      end
    end
    return TW'(r);
  endfunction

  // Input fields
  arlp_pkg::action_t action;
  logic [SW-1:0]     in_left;
  logic [SW-1:0]     in_right;
  logic [7:0]        tone_index;

  assign action     = arlp_pkg::action_t'(s_tuser);
  assign in_left    = s_tdata[15:0];
  assign in_right   = s_tdata[31:16];
  assign tone_index = s_tdata[39:32];

  // Architectural state
  logic [7:0]          phase_step;
  arlp_pkg::mode_t     mode, mode_next;
  logic [5:0]          volume, volume_next;
  logic [7:0]          tone_phase, tone_phase_next;
  logic [LW-1:0]       record_length, record_length_next;
  logic [AW-1:0]       play_position, play_position_next;

  // Tone table clear after reset
  logic          clr_busy;
  logic [TW-1:0] clr_idx;

  // Read stage and output register
  logic              s1_valid;
  arlp_pkg::src_t    s1_src, src;
  logic [SW-1:0]     s1_left, s1_right;
  logic              s1_sample;
  arlp_pkg::mode_t   s1_mode;
  logic [5:0]        s1_volume;
  logic [CW-1:0]     s1_count;
  logic              s1_rej, rej;

  logic m_load, accept;

  // Memory ports
  logic          store_we, store_re;
  logic [AW-1:0] store_waddr, store_raddr;
  logic [31:0]   store_rdata;
  logic          table_we, table_re;
  logic [TW-1:0] table_waddr, table_raddr;
  logic [SW-1:0] table_wdata, table_rdata;

  // Playback address helpers
  logic [AW-1:0] pos_cur;
  logic [LW-1:0] pos_inc;
  logic [6:0]    vol_sum;

  // Handshake
  assign m_load   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !clr_busy && (!s1_valid || m_load);
  assign accept   = s_tvalid && s_tready;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr == arlp_pkg::ADDR_PHASE_STEP) ? 32'(phase_step) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= arlp_pkg::PHASE_STEP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == arlp_pkg::ADDR_PHASE_STEP) begin
      phase_step <= pwdata[7:0];
    end
  end

  // Playback position for this frame and the one after it
  assign pos_cur = (LW'(play_position) >= record_length) ? '0 : play_position;
  assign pos_inc = LW'(pos_cur) + LW'(1);
  assign vol_sum = 7'(volume) + 7'(arlp_pkg::VOLUME_STEP);

  // Next state and memory requests for the item at the input
  always_comb begin
    mode_next          = mode;
    volume_next        = volume;
    tone_phase_next    = tone_phase;
    record_length_next = record_length;
    play_position_next = play_position;
    src                = arlp_pkg::SRC_ZERO;
    rej                = 1'b0;
    store_we           = 1'b0;
    store_re           = 1'b0;
    table_re           = 1'b0;
    unique case (action)
      arlp_pkg::ACT_FRAME: begin
        unique case (mode)
          arlp_pkg::MODE_PASS: begin
            src = arlp_pkg::SRC_INPUT;
          end
          arlp_pkg::MODE_TONE: begin
            src             = arlp_pkg::SRC_TONE;
            table_re        = accept;
            tone_phase_next = tone_phase + phase_step;
          end
          arlp_pkg::MODE_REC: begin
            src = arlp_pkg::SRC_INPUT;
            if (record_length < LW'(RECORD_FRAMES)) begin
              store_we           = accept;
              record_length_next = record_length + LW'(1);
            end else begin
              mode_next = arlp_pkg::MODE_PASS;
            end
          end
          arlp_pkg::MODE_PLAY: begin
            if (record_length != '0) begin
              src                = arlp_pkg::SRC_STORE;
              store_re           = accept;
              play_position_next = (pos_inc >= record_length) ? '0 : pos_inc[AW-1:0];
            end
          end
        endcase
      end
      arlp_pkg::ACT_PASS: mode_next = arlp_pkg::MODE_PASS;
      arlp_pkg::ACT_TONE: mode_next = arlp_pkg::MODE_TONE;
      arlp_pkg::ACT_REC: begin
        record_length_next = '0;
        mode_next          = arlp_pkg::MODE_REC;
      end
      arlp_pkg::ACT_PLAY: begin
        if (record_length != '0) begin
          play_position_next = '0;
          mode_next          = arlp_pkg::MODE_PLAY;
        end else begin
          rej = 1'b1;
        end
      end
      arlp_pkg::ACT_VOL_UP: begin
        volume_next = (vol_sum > 7'(arlp_pkg::VOLUME_MAX)) ? arlp_pkg::VOLUME_MAX
                                                           : vol_sum[5:0];
      end
      arlp_pkg::ACT_VOL_DOWN: begin
        volume_next = (volume < arlp_pkg::VOLUME_STEP) ? 6'd0
                                                       : volume - arlp_pkg::VOLUME_STEP;
      end
      arlp_pkg::ACT_TABLE_WR: ;
    endcase
  end

  // Memory addressing; the clear sweep owns the table write port while it runs
  assign store_waddr = record_length[AW-1:0];
  assign store_raddr = pos_cur;
  assign table_raddr = tone_addr(tone_phase);

  always_comb begin
    if (clr_busy) begin
      table_we    = 1'b1;
      table_waddr = clr_idx;
      table_wdata = '0;
    end else begin
      table_we    = accept && action == arlp_pkg::ACT_TABLE_WR &&
                    11'(tone_index) < 11'(TONE_ENTRIES);
      table_waddr = TW'(tone_index);
      table_wdata = in_left;
    end
  end

  arlp_ram #(.WIDTH(32), .DEPTH(RECORD_FRAMES)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata ({in_right, in_left}),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  arlp_ram #(.WIDTH(SW), .DEPTH(TONE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (table_waddr),
    .wdata (table_wdata),
    .re    (table_re),
    .raddr (table_raddr),
    .rdata (table_rdata)
  );

  // State registers and the clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= arlp_pkg::MODE_PASS;
      volume        <= arlp_pkg::VOLUME_RESET;
      tone_phase    <= 8'd0;
      record_length <= '0;
      play_position <= '0;
      clr_busy      <= 1'b1;
      clr_idx       <= '0;
    end else begin
      if (accept) begin
        mode          <= mode_next;
        volume        <= volume_next;
        tone_phase    <= tone_phase_next;
        record_length <= record_length_next;
        play_position <= play_position_next;
      end
      if (clr_busy) begin
        clr_idx <= clr_idx + TW'(1);
        if (clr_idx == TW'(TONE_ENTRIES - 1)) begin
          clr_busy <= 1'b0;
        end
      end
    end
  end

  // Read stage: holds the item while its memory read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (m_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src    <= src;
      s1_left   <= in_left;
      s1_right  <= in_right;
      s1_sample <= (action == arlp_pkg::ACT_FRAME);
      s1_mode   <= mode_next;
      s1_volume <= volume_next;
      s1_count  <= CW'(record_length_next);
      s1_rej    <= rej;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (m_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_load) begin
      unique case (s1_src)
        arlp_pkg::SRC_INPUT: m_tdata[31:0] <= {s1_right, s1_left};
        arlp_pkg::SRC_TONE:  m_tdata[31:0] <= {table_rdata, table_rdata};
        arlp_pkg::SRC_STORE: m_tdata[31:0] <= store_rdata;
        arlp_pkg::SRC_ZERO:  m_tdata[31:0] <= 32'd0;
      endcase
      m_tdata[55:32] <= {s1_rej, s1_count, s1_volume, s1_mode};
      m_tuser        <= s1_sample;
    end
  end

  // Checks
  `ARLP_ASSERT_NOW(a_no_accept_in_clear, clr_busy, !s_tready,
                   "item accepted during tone table clear")
  `ARLP_ASSERT_NOW(a_length_bound, 1'b1, record_length <= LW'(RECORD_FRAMES),
                   "record length beyond store size")
  `ARLP_ASSERT_NOW(a_play_in_range, mode == arlp_pkg::MODE_PLAY,
                   LW'(play_position) < record_length,
                   "playback position outside recorded frames")
  `ARLP_ASSERT_NOW(a_store_one_access, 1'b1, !(store_we && store_re),
                   "record store written and read in one cycle")
  `ARLP_ASSERT_NEXT(a_stall_holds_result, m_tvalid && !m_tready, m_tvalid,
                    "pending result dropped while stalled")

endmodule

[design/arlp_ram.sv]
module arlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; rdata holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
